// ----- src/psched_pkg.sv -----
`default_nettype none
package psched_pkg;

	// process table size
	localparam int unsigned MAX_PROCS = 16;
	localparam int unsigned IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);

	// field widths
	localparam int unsigned ARR_W   = 16;
	localparam int unsigned BURST_W = 16;
	localparam int unsigned PRIO_W  = 8;
	localparam int unsigned PIDX_W  = 6;
	localparam int unsigned WOUT_W  = 24;
	localparam int unsigned TOTAL_W = 32;
	localparam int unsigned TIME_W  = 21;
	localparam int unsigned WAIT_W  = 21;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_EMIT_LOAD,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sim_init;
		logic scan_step;
		logic jump;
		logic span_set;
		logic update_step;
		logic emit_init;
		logic emit_load;
		logic emit_next;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic at_last;
		logic pending;
		logic have_sel;
	} status_t;

endpackage
`default_nettype wire

// ----- src/psched_in_if.sv -----
`default_nettype none
interface psched_in_if import psched_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ARR_W-1:0]     arrival_time;
	logic [BURST_W-1:0]   burst_time;
	logic [PRIO_W-1:0]    priority_req;
	logic                 last;

	modport source (
		output valid, arrival_time, burst_time, priority_req, last,
		input  ready
	);
	modport sink (
		input  valid, arrival_time, burst_time, priority_req, last,
		output ready
	);
endinterface
`default_nettype wire

// ----- src/psched_out_if.sv -----
`default_nettype none
interface psched_out_if import psched_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PIDX_W-1:0]    process_index;
	logic [WOUT_W-1:0]    waiting_time;
	logic [TOTAL_W-1:0]   total_waiting;
	logic                 last_result;

	modport source (
		output valid, process_index, waiting_time, total_waiting, last_result,
		input  ready
	);
	modport sink (
		input  valid, process_index, waiting_time, total_waiting, last_result,
		output ready
	);
endinterface
`default_nettype wire

// ----- src/psched_dp.sv -----
`default_nettype none
module psched_dp import psched_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	input  wire logic [ARR_W-1:0]     arrival_time,
	input  wire logic [BURST_W-1:0]   burst_time,
	input  wire logic [PRIO_W-1:0]    priority_req,
	output logic [PIDX_W-1:0]         process_index,
	output logic [WOUT_W-1:0]         waiting_time,
	output logic [TOTAL_W-1:0]        total_waiting,
	output logic                      last_result
);

	logic [ARR_W-1:0]   arr_mem  [MAX_PROCS];
	logic [BURST_W-1:0] rem_mem  [MAX_PROCS];
	logic [PRIO_W-1:0]  prio_mem [MAX_PROCS];
	logic [WAIT_W-1:0]  wait_mem [MAX_PROCS];

	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [TIME_W-1:0]  time_q;

	logic               pend_q;
	logic               sel_v_q;
	logic [IDX_W-1:0]   sel_idx_q;
	logic [PRIO_W-1:0]  sel_prio_q;
	logic [BURST_W-1:0] sel_rem_q;
	logic               nxt_v_q;
	logic [ARR_W-1:0]   nxt_arr_q;
	logic [BURST_W-1:0] span_q;

	logic [ARR_W-1:0]   rd_arr;
	logic [BURST_W-1:0] rd_rem;
	logic [PRIO_W-1:0]  rd_prio;
	logic [WAIT_W-1:0]  rd_wait;
	logic               rd_active;
	logic               rd_ready;
	logic               at_last;
	logic               room;
	logic [TIME_W-1:0]  gap;
	logic [BURST_W-1:0] span_d;

	// entry under the scan index
	assign rd_arr    = arr_mem[idx_q];
	assign rd_rem    = rem_mem[idx_q];
	assign rd_prio   = prio_mem[idx_q];
	assign rd_wait   = wait_mem[idx_q];
	assign rd_active = (rd_rem != '0);
	assign rd_ready  = rd_active && (TIME_W'(rd_arr) <= time_q);

	assign at_last = ({1'b0, idx_q} == CNT_W'(cnt_q - CNT_W'(1)));
	assign room    = (cnt_q < CNT_W'(MAX_PROCS));

	// run length: until the selected process ends or the next arrival
	assign gap    = TIME_W'(nxt_arr_q) - time_q;
	assign span_d = (nxt_v_q && (gap < TIME_W'(sel_rem_q))) ? gap[BURST_W-1:0] : sel_rem_q;

	assign status.at_last  = at_last;
	assign status.pending  = pend_q;
	assign status.have_sel = sel_v_q;

	// process table writes
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			arr_mem[cnt_q[IDX_W-1:0]]  <= arrival_time;
			rem_mem[cnt_q[IDX_W-1:0]]  <= burst_time;
			prio_mem[cnt_q[IDX_W-1:0]] <= priority_req;
			wait_mem[cnt_q[IDX_W-1:0]] <= '0;
		end else if (cmd.update_step) begin
			if (idx_q == sel_idx_q) begin
				rem_mem[idx_q] <= rd_rem - span_q;
			end else if (rd_ready) begin
				wait_mem[idx_q] <= rd_wait + WAIT_W'(span_q);
			end
		end
	end

	// record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load && room) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.emit_next && at_last) begin
			cnt_q <= '0;
		end
	end

	// scan index and simulation time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			time_q <= '0;
		end else if (cmd.sim_init) begin
			idx_q  <= '0;
			time_q <= '0;
		end else if (cmd.jump) begin
			idx_q  <= '0;
			time_q <= TIME_W'(nxt_arr_q);
		end else if (cmd.emit_init) begin
			idx_q <= '0;
		end else if (cmd.scan_step || cmd.emit_next) begin
			idx_q <= at_last ? '0 : idx_q + IDX_W'(1);
		end else if (cmd.update_step) begin
			idx_q <= at_last ? '0 : idx_q + IDX_W'(1);
			if (at_last) begin
				time_q <= time_q + TIME_W'(span_q);
			end
		end
	end

	// selection and next-arrival search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			sel_v_q <= 1'b0;
			nxt_v_q <= 1'b0;
		end else if (cmd.sim_init || cmd.jump || (cmd.update_step && at_last)) begin
			pend_q  <= 1'b0;
			sel_v_q <= 1'b0;
			nxt_v_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (rd_active) begin
				pend_q <= 1'b1;
			end
			if (rd_ready && (!sel_v_q || rd_prio < sel_prio_q)) begin
				sel_v_q <= 1'b1;
			end
			if (rd_active && !rd_ready && (!nxt_v_q || rd_arr < nxt_arr_q)) begin
				nxt_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			if (rd_ready && (!sel_v_q || rd_prio < sel_prio_q)) begin
				sel_idx_q  <= idx_q;
				sel_prio_q <= rd_prio;
				sel_rem_q  <= rd_rem;
			end
			if (rd_active && !rd_ready && (!nxt_v_q || rd_arr < nxt_arr_q)) begin
				nxt_arr_q <= rd_arr;
			end
		end
		if (cmd.span_set) begin
			span_q <= span_d;
		end
	end

	// result register and running total
	always_ff @(posedge clk) begin
		if (cmd.emit_init) begin
			total_waiting <= '0;
		end else if (cmd.emit_load) begin
			process_index <= PIDX_W'(idx_q);
			waiting_time  <= WOUT_W'(rd_wait);
			total_waiting <= total_waiting + TOTAL_W'(rd_wait);
			last_result   <= at_last;
		end
	end

endmodule
`default_nettype wire

// ----- src/psched_ctrl.sv -----
`default_nettype none
module psched_ctrl import psched_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire status_t  status,
	output cmd_t          cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_last) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.at_last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!status.pending) state_d = ST_EMIT_LOAD;
				else if (!status.have_sel) state_d = ST_SCAN;
				else state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (status.at_last) state_d = ST_SCAN;
			end
			ST_EMIT_LOAD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready) state_d = status.at_last ? ST_IDLE : ST_EMIT_LOAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands and handshake
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load     = in_valid;
				cmd.sim_init = in_valid && in_last;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DECIDE: begin
				cmd.emit_init = !status.pending;
				cmd.jump      = status.pending && !status.have_sel;
				cmd.span_set  = status.pending && status.have_sel;
			end
			ST_UPDATE: begin
				cmd.update_step = 1'b1;
			end
			ST_EMIT_LOAD: begin
				cmd.emit_load = 1'b1;
			end
			ST_EMIT: begin
				out_valid     = 1'b1;
				cmd.emit_next = out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/preemptive_priority_scheduler_sim.sv -----
// Preemptive priority scheduler. Process records (arrival, burst, priority) load one beat per
// cycle into a 16-entry table; records past the sixteenth are dropped. The beat marked last
// starts the simulation and input stalls until every result has been delivered. The simulation
// moves from event to event (an arrival or a completion): each event costs one scan of the table
// plus, when a process runs, one update pass over the stored entries, with at most about 2n
// events for n records plus idle jumps. The lowest priority value runs, ties go to the lowest
// index, zero-burst records count as done. Results then leave in load order, one at a time:
// each is loaded into the result register, then offered until the sink takes it, with the
// running total of waiting times and a flag on the final one.
`default_nettype none
module preemptive_priority_scheduler_sim import psched_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	psched_in_if.sink     records,
	psched_out_if.source  results
);

	cmd_t    cmd;
	status_t status;

	// sequencing
	psched_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (records.valid),
		.in_last   (records.last),
		.in_ready  (records.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// process table, search and result registers
	psched_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.arrival_time  (records.arrival_time),
		.burst_time    (records.burst_time),
		.priority_req  (records.priority_req),
		.process_index (results.process_index),
		.waiting_time  (results.waiting_time),
		.total_waiting (results.total_waiting),
		.last_result   (results.last_result)
	);

endmodule
`default_nettype wire
